@@ rtl/core/dmc_pkg.sv @@
package dmc_pkg;

    localparam int MAX_SIDE_DEF    = 64;
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int MIN_SIDE        = 5;
    localparam int RESET_SIDE      = 15;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // neighbour directions, in search order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_MOD,
        S_PLACE,
        S_EMIT_A,
        S_EMIT_B,
        S_RD_TOP,
        S_TOP,
        S_NB_RD,
        S_NB_CK,
        S_PICK,
        S_CARVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        step;
        logic [1:0]  ent;
        logic [1:0]  ext;
        logic [15:0] ra;
        logic [15:0] rb;
    } t_cmd;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic       done;
        logic       last;
    } t_res;

    // residue mod 3 by summing base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] a;
        logic [2:0] b;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + {3'b000, v[2*k +: 2]};
        end
        a = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
        b = {1'b0, a[1:0]} + {2'b00, a[2]};
        if (b >= 3'd3) begin
            b = b - 3'd3;
        end
        return b[1:0];
    endfunction

    // candidate number (r mod count) among the set bits, as a direction
    function automatic logic [1:0] pick_dir(input logic [15:0] r, input logic [3:0] cand);
        logic [2:0] nc;
        logic [1:0] k;
        logic [1:0] seen;
        logic [1:0] dir;
        nc   = 3'($countones(cand));
        seen = '0;
        dir  = DIR_UP;
        case (nc)
            3'd2:    k = {1'b0, r[0]};
            3'd3:    k = mod3_16(r);
            3'd4:    k = r[1:0];
            default: k = 2'd0;
        endcase
        for (int d = 3; d >= 0; d--) begin
            if (cand[d]) begin
                seen = seen;
            end
        end
        for (int d = 0; d < 4; d++) begin
            if (cand[d]) begin
                if (seen == k) begin
                    dir = 2'(d);
                end
                seen = seen + 2'd1;
            end
        end
        return dir;
    endfunction

endpackage

@@ rtl/core/dmc_fifo.sv @@
module dmc_fifo
    import dmc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [NW-1:0]    r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

@@ rtl/core/dmc_front.sv @@
module dmc_front
    import dmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [15:0] i_rand_a,
    input  logic [15:0] i_rand_b,
    input  logic        i_pop,
    output logic        o_empty,
    output t_cmd        o_cmd
);
    t_cmd       cls;
    logic [1:0] k;
    logic [$bits(t_cmd)-1:0] q_data;

    // exit side: one of the three sides other than the entrance, ascending code
    always_comb begin
        k        = mod3_16({8'h00, i_rand_b[7:0]});
        cls.step = i_cmd;
        cls.ent  = i_rand_a[1:0];
        cls.ext  = (k < i_rand_a[1:0]) ? k : k + 2'd1;
        cls.ra   = i_rand_a;
        cls.rb   = i_rand_b;
    end

    dmc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (o_empty)
    );

    assign o_cmd = t_cmd'(q_data);
endmodule

@@ rtl/core/dmc_back.sv @@
module dmc_back
    import dmc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_empty,
    output logic                                 o_cmd_pop,
    input  t_cmd                                 i_cmd,
    input  logic [$clog2(MAX_SIDE_DEF+1)-1:0]    i_w,
    input  logic [$clog2(MAX_SIDE_DEF+1)-1:0]    i_h,
    input  logic                                 i_res_full,
    output logic                                 o_res_push,
    output t_res                                 o_res
);
    localparam int MAX_SIDE = MAX_SIDE_DEF;
    localparam int XW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = 2 * XW;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int GW = XW + 2;

    logic             r_vis [2**AW];
    logic [AW-1:0]    r_stk [STACK_DEPTH];

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic [AW:0]      r_addr, n_addr;
    logic [13:0]      r_shift, n_shift;
    logic [SW-1:0]    r_rem, n_rem;
    logic [3:0]       r_bitcnt, n_bitcnt;
    logic             r_phase, n_phase;
    logic [XW-1:0]    r_ex, n_ex, r_ey, n_ey, r_xx, n_xx, r_xy, n_xy;
    logic [XW-1:0]    r_tx, n_tx, r_ty, n_ty;
    logic [1:0]       r_dir, n_dir;
    logic [3:0]       r_cand, n_cand;
    logic             r_inb, n_inb;
    logic             r_i, n_i;
    logic [CW-1:0]    r_count, n_count;
    logic             r_first, n_first;
    logic             r_over, n_over;
    logic [1:0]       r_entry_side, n_entry_side;
    logic             r_vis_q;
    logic [AW-1:0]    r_top_q;

    logic             vis_we, vis_wd, stk_we;
    logic [AW-1:0]    vis_wa, vis_ra, stk_wd;
    logic [IW-1:0]    stk_ra, stk_wa;

    // shared helpers
    logic [1:0]       code;
    logic [SW-1:0]    along, across, nmod;
    logic [SW:0]      trial;
    logic [XW-1:0]    pos, edge_c;
    logic [XW-1:0]    cx_clr, cy_clr;
    logic [XW:0]      wx, hx;
    logic             border;
    logic signed [GW-1:0] sx, sy, sw1, sh1;
    logic [XW-1:0]    cx, cy, stepv;
    logic [2:0]       nc;
    logic             can_move, is_last;

    // ---------------- datapath helpers ----------------
    always_comb begin
        code   = r_phase ? r_cmd.ext : r_cmd.ent;
        along  = code[0] ? i_h : i_w;
        across = code[0] ? i_w : i_h;
        nmod   = (along >> 1) - SW'(1);
        trial  = {r_rem, r_shift[13]};
        if (trial >= {1'b0, nmod}) begin
            trial = trial - {1'b0, nmod};
        end
        pos    = XW'({r_rem, 1'b1});
        edge_c = code[1] ? XW'(across - SW'(1)) : '0;

        cx_clr = r_addr[XW-1:0];
        cy_clr = r_addr[AW-1:XW];
        wx     = (XW+1)'(i_w);
        hx     = (XW+1)'(i_h);
        border = ({1'b0, cx_clr} < wx) && ({1'b0, cy_clr} < hx) &&
                 (cx_clr == '0 || cy_clr == '0 ||
                  {1'b0, cx_clr} == wx - 1'b1 || {1'b0, cy_clr} == hx - 1'b1);

        sx  = $signed({2'b00, r_tx});
        sy  = $signed({2'b00, r_ty});
        case (r_dir)
            DIR_UP:    sy = sy - GW'(2);
            DIR_DOWN:  sy = sy + GW'(2);
            DIR_LEFT:  sx = sx - GW'(2);
            DIR_RIGHT: sx = sx + GW'(2);
            default:   sx = sx;
        endcase
        sw1 = $signed(GW'(i_w)) - GW'(1);
        sh1 = $signed(GW'(i_h)) - GW'(1);

        stepv = r_i ? XW'(2) : XW'(1);
        cx    = r_tx;
        cy    = r_ty;
        case (r_dir)
            DIR_UP:    cy = r_ty - stepv;
            DIR_DOWN:  cy = r_ty + stepv;
            DIR_LEFT:  cx = r_tx - stepv;
            DIR_RIGHT: cx = r_tx + stepv;
            default:   cx = r_tx;
        endcase

        nc       = 3'($countones(r_cand));
        can_move = (nc != 3'd0) &&
                   ((r_count + (r_first ? CW'(1) : CW'(2))) <= CW'(STACK_DEPTH));
        is_last  = r_first ? 1'b1 : r_i;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.step == CMD_START) begin
                        n_state = S_CLR;
                    end else if (r_over || r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD_TOP;
                    end
                end
            end
            S_CLR:    if (r_addr == (AW+1)'(2**AW - 1)) n_state = S_MOD;
            S_MOD:    if (r_bitcnt == 4'd13) n_state = S_PLACE;
            S_PLACE:  n_state = r_phase ? S_EMIT_A : S_MOD;
            S_EMIT_A: if (!i_res_full) n_state = S_EMIT_B;
            S_EMIT_B: if (!i_res_full) n_state = S_IDLE;
            S_RD_TOP: n_state = S_TOP;
            S_TOP:    n_state = S_NB_RD;
            S_NB_RD:  n_state = S_NB_CK;
            S_NB_CK:  n_state = (r_dir == DIR_RIGHT) ? S_PICK : S_NB_RD;
            S_PICK: begin
                if (can_move) begin
                    n_state = S_CARVE;
                end else if (r_first || (r_count - CW'(1)) <= CW'(2)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CARVE:  if (!i_res_full && is_last) n_state = S_IDLE;
            S_DONE:   if (!i_res_full) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        vis_we       = 1'b0;
        vis_wa       = {r_addr[AW-1:XW], r_addr[XW-1:0]};
        vis_wd       = border;
        vis_ra       = {sy[XW-1:0], sx[XW-1:0]};
        stk_we       = 1'b0;
        stk_wd       = {r_ey, r_ex};
        stk_wa       = r_count[IW-1:0];
        stk_ra       = IW'(r_count - CW'(1));
        n_addr       = r_addr;
        n_shift      = r_shift;
        n_rem        = r_rem;
        n_bitcnt     = r_bitcnt;
        n_phase      = r_phase;
        n_ex         = r_ex;
        n_ey         = r_ey;
        n_xx         = r_xx;
        n_xy         = r_xy;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_dir        = r_dir;
        n_cand       = r_cand;
        n_inb        = r_inb;
        n_i          = r_i;
        n_count      = r_count;
        n_first      = r_first;
        n_over       = r_over;
        n_entry_side = r_entry_side;
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                n_addr    = '0;
                if (!i_cmd_empty && i_cmd.step == CMD_STEP && (r_over || r_count == '0)) begin
                    n_over = 1'b1;
                end
            end
            S_CLR: begin
                vis_we   = 1'b1;
                n_addr   = r_addr + 1'b1;
                n_shift  = r_cmd.ra[15:2];
                n_rem    = '0;
                n_bitcnt = '0;
                n_phase  = 1'b0;
            end
            S_MOD: begin
                n_rem    = trial[SW-1:0];
                n_shift  = {r_shift[12:0], 1'b0};
                n_bitcnt = r_bitcnt + 4'd1;
            end
            S_PLACE: begin
                n_rem    = '0;
                n_bitcnt = '0;
                n_shift  = {6'b000000, r_cmd.rb[15:8]};
                n_phase  = 1'b1;
                if (!r_phase) begin
                    n_ex = code[0] ? edge_c : pos;
                    n_ey = code[0] ? pos : edge_c;
                end else begin
                    n_xx         = code[0] ? edge_c : pos;
                    n_xy         = code[0] ? pos : edge_c;
                    // entrance goes to the bottom of a fresh stack
                    stk_we       = 1'b1;
                    stk_wa       = '0;
                    n_count      = CW'(1);
                    n_first      = 1'b1;
                    n_over       = 1'b0;
                    n_entry_side = r_cmd.ent;
                end
            end
            S_EMIT_A: begin
                o_res_push = !i_res_full;
                o_res.x    = 6'(r_ex);
                o_res.y    = 6'(r_ey);
            end
            S_EMIT_B: begin
                o_res_push = !i_res_full;
                o_res.x    = 6'(r_xx);
                o_res.y    = 6'(r_xy);
                o_res.last = 1'b1;
            end
            S_TOP: begin
                n_tx   = r_top_q[XW-1:0];
                n_ty   = r_top_q[AW-1:XW];
                n_dir  = DIR_UP;
                n_cand = '0;
            end
            S_NB_RD: begin
                n_inb = (sx > 0) && (sx < sw1) && (sy > 0) && (sy < sh1);
            end
            S_NB_CK: begin
                n_cand[r_dir] = r_inb && !r_vis_q;
                n_dir         = r_dir + 2'd1;
            end
            S_PICK: begin
                n_i     = 1'b0;
                n_dir   = pick_dir(r_cmd.ra, r_cand);
                if (!can_move) begin
                    n_first = 1'b0;
                    if (r_first || (r_count - CW'(1)) <= CW'(2)) begin
                        n_over = 1'b1;
                    end else begin
                        n_count = r_count - CW'(2);
                    end
                end
            end
            S_CARVE: begin
                vis_wa = {cy, cx};
                vis_wd = 1'b1;
                stk_wd = {cy, cx};
                if (!i_res_full) begin
                    vis_we     = 1'b1;
                    stk_we     = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_i        = 1'b1;
                    n_first    = 1'b0;
                    o_res_push = 1'b1;
                    o_res.x    = 6'(cx);
                    o_res.y    = 6'(cy);
                    o_res.last = is_last;
                end
            end
            S_DONE: begin
                o_res_push = !i_res_full;
                o_res.done = 1'b1;
                o_res.last = 1'b1;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_first      <= 1'b1;
            r_over       <= 1'b1;
            r_entry_side <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_first      <= n_first;
            r_over       <= n_over;
            r_entry_side <= n_entry_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        r_addr   <= n_addr;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_bitcnt <= n_bitcnt;
        r_phase  <= n_phase;
        r_ex     <= n_ex;
        r_ey     <= n_ey;
        r_xx     <= n_xx;
        r_xy     <= n_xy;
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_dir    <= n_dir;
        r_cand   <= n_cand;
        r_inb    <= n_inb;
        r_i      <= n_i;
    end

    // visited map and path stack
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis[vis_wa] <= vis_wd;
        end
        r_vis_q <= r_vis[vis_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_top_q <= r_stk[stk_ra];
    end
endmodule

@@ rtl/core/dfs_maze_carver_core.sv @@
// Randomised depth-first maze carver. Commands go in through a queue-style
// push/full port and cell results come out through an empty/pop port; two
// small queues separate both sides from the engine. A start command sweeps
// the whole visited map and then finds the entrance and exit positions with
// a bit-serial remainder unit, giving the entrance then the exit. A step
// command reads the stack top, probes the four neighbours two away one at a
// time through the single memory port, then carves: one cell on a first
// move, two cells otherwise, and at a dead end it pops the stack or, when
// the search ends there, gives a done result. Results wait in the output
// queue; the engine stalls while it is full.
// Effective width and height are the configured values held to 5..MAX_SIDE
// and made odd.
module dfs_maze_carver_core
    import dmc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    // command side
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [15:0] i_rand_a,
    input  logic [15:0] i_rand_b,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_cell_x,
    output logic [5:0]  o_cell_y,
    output logic        o_done_res,
    output logic        o_last
);
    localparam int MAX_SIDE = MAX_SIDE_DEF;
    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [6:0]    r_grid_width, r_grid_height;
    logic [SW-1:0] eff_w, eff_h;

    t_cmd          q_cmd;
    logic          q_empty, q_pop;
    t_res          res_in;
    logic          res_push, res_full;
    logic [$bits(t_res)-1:0] res_q;
    t_res          res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'(RESET_SIDE);
            r_grid_height <= 7'(RESET_SIDE);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end else begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    // saturate and round down to odd
    always_comb begin
        int vw;
        int vh;
        vw = int'(r_grid_width);
        vh = int'(r_grid_height);
        if (vw > MAX_SIDE) vw = MAX_SIDE;
        if (vw < MIN_SIDE) vw = MIN_SIDE;
        if (vw % 2 == 0)   vw = vw - 1;
        if (vh > MAX_SIDE) vh = MAX_SIDE;
        if (vh < MIN_SIDE) vh = MIN_SIDE;
        if (vh % 2 == 0)   vh = vh - 1;
        eff_w = SW'(vw);
        eff_h = SW'(vh);
    end

    dmc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_cmd    (i_cmd),
        .i_rand_a (i_rand_a),
        .i_rand_b (i_rand_b),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_cmd    (q_cmd)
    );

    dmc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .i_w         (eff_w),
        .i_h         (eff_h),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // each result transfer leaves from here
    dmc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out    = t_res'(res_q);
    assign o_cell_x   = res_out.x;
    assign o_cell_y   = res_out.y;
    assign o_done_res = res_out.done;
    assign o_last     = res_out.last;
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Bench for the maze carver: commands go in through the push/full side, cells
// come out through the empty/pop side and are checked against a local model.
module tb_top;
    import dmc_pkg::*;

    localparam int SIDE       = 64;
    localparam int DEPTH      = 4096;
    localparam int DRAIN_WAIT = 60;    // a dead-end step gives nothing back
    localparam int HOLD_LEN   = 400;   // long receiver hold-off
    localparam int WDOG_LIMIT = 40000; // a start sweeps the whole map first

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [6:0]  i_cfg_data;
    logic        push;
    logic        full;
    logic        i_cmd;
    logic [15:0] i_rand_a;
    logic [15:0] i_rand_b;
    logic        empty;
    logic        pop;
    logic [5:0]  o_cell_x;
    logic [5:0]  o_cell_y;
    logic        o_done_res;
    logic        o_last;

    dfs_maze_carver_core uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Local copy of the carver state
    // ---------------------------------------------------------------
    logic [6:0]  req_w, req_h;
    logic [1:0]  map_cells [SIDE*SIDE];
    logic [11:0] trail [DEPTH];
    int          trail_len;
    bit          first_hop;
    bit          maze_over;

    t_res cells_due[$];   // cells and done flags still to come out
    int   n_errors;
    bit   hold_out;       // asks the receiver for a long hold-off
    bit   burst_in, burst_out;
    int   in_gap;         // wait before the next transfer on the input side

    function automatic int eff_side(input logic [6:0] r);
        int v;
        v = r;
        if (v > SIDE) v = SIDE;
        if (v < MIN_SIDE) v = MIN_SIDE;
        if (v % 2 == 0) v--;
        return v;
    endfunction

    // border cell for side code (axis + 2*side) and position word
    function automatic void border_pos(input int code, input int r, input int w, input int h,
                                       output int x, output int y);
        int along, across, n, pos, edge_at;
        along   = code[0] ? h : w;
        across  = code[0] ? w : h;
        n       = (along + 1) / 2 - 2;
        pos     = 2 * (r % n) + 1;
        edge_at = code[1] ? across - 1 : 0;
        if (!code[0]) begin
            x = pos; y = edge_at;
        end else begin
            x = edge_at; y = pos;
        end
    endfunction

    function automatic t_res mk_res(input int x, input int y, input bit dn, input bit lst);
        t_res r;
        r.x = 6'(x); r.y = 6'(y); r.done = dn; r.last = lst;
        return r;
    endfunction

    function automatic void add_due(input t_res r);
        cells_due = {cells_due, r};
    endfunction

    function automatic void drop_last();
        cells_due.delete(cells_due.size() - 1);
    endfunction

    // Advance the local maze by one command and queue the cells it opens or the done flag.
    function automatic void carve_expect(input logic cmd, input logic [15:0] ra,
                                         input logic [15:0] rb);
        int dxs[4] = '{0, 0, -1, 1};
        int dys[4] = '{-1, 1, 0, 0};
        int w, h, x, y, x2, y2, ent, ex, k;
        int tx, ty, nx, ny, nc, need, c, cx, cy;
        int cand[4];
        bit was_first;
        w = eff_side(req_w);
        h = eff_side(req_h);
        if (cmd == CMD_START) begin
            foreach (map_cells[i]) map_cells[i] = 2'b00;
            for (int yy = 0; yy < h; yy++)
                for (int xx = 0; xx < w; xx++)
                    if (yy == 0 || yy == h-1 || xx == 0 || xx == w-1)
                        map_cells[yy*SIDE + xx] = 2'b10;
            ent = ra[1:0];
            k   = rb[7:0] % 3;
            ex  = (k < ent) ? k : k + 1;
            border_pos(ent, ra[15:2], w, h, x, y);
            border_pos(ex, rb[15:8], w, h, x2, y2);
            map_cells[y*SIDE + x]   = 2'b11;
            map_cells[y2*SIDE + x2] = 2'b11;
            trail[0]   = 12'(y*SIDE + x);
            trail_len  = 1;
            first_hop  = 1'b1;
            maze_over  = 1'b0;
            add_due(mk_res(x, y, 1'b0, 1'b0));
            add_due(mk_res(x2, y2, 1'b0, 1'b1));
            return;
        end
        if (maze_over || trail_len == 0 || trail_len > DEPTH) begin
            maze_over = 1'b1;
            add_due(mk_res(0, 0, 1'b1, 1'b1));
            return;
        end
        tx = trail[trail_len-1] % SIDE;
        ty = trail[trail_len-1] / SIDE;
        need = first_hop ? 1 : 2;
        was_first = first_hop;
        first_hop = 1'b0;
        nc = 0;
        for (int d = 0; d < 4; d++) begin
            nx = tx + 2*dxs[d];
            ny = ty + 2*dys[d];
            if (nx > 0 && nx < w-1 && ny > 0 && ny < h-1 && !map_cells[ny*SIDE + nx][1]) begin
                cand[nc] = d;
                nc++;
            end
        end
        if (nc > 0 && trail_len + need <= DEPTH) begin
            c = cand[ra % nc];
            for (int i = 1; i <= need; i++) begin
                cx = tx + i*dxs[c];
                cy = ty + i*dys[c];
                map_cells[cy*SIDE + cx] = 2'b11;
                trail[trail_len] = 12'(cy*SIDE + cx);
                trail_len++;
                add_due(mk_res(cx, cy, 1'b0, i == need));
            end
        end else if (was_first || trail_len - 1 <= 2) begin
            maze_over = 1'b1;
            add_due(mk_res(0, 0, 1'b1, 1'b1));
        end else begin
            trail_len -= 2;
        end
    endfunction

    // wait drawn per transfer, with runs of back-to-back transfers
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 23) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_cmd(input logic cmd, input logic [15:0] ra, input logic [15:0] rb,
                            input bit typed, input t_res t0, input t_res t1);
        if (in_gap > 0) begin
            push <= 1'b0;
            repeat (in_gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_cmd    <= cmd;
        i_rand_a <= ra;
        i_rand_b <= rb;
        do @(posedge i_clk); while (full);
        // transfer taken at this edge
        carve_expect(cmd, ra, rb);
        if (typed) begin
            // hand-worked values replace the model's for this row
            drop_last();
            if (cmd == CMD_START) begin
                drop_last();
                add_due(t0);
                add_due(t1);
            end else begin
                add_due(t0);
            end
        end
        in_gap = hold_out ? 0 : draw_wait(burst_in);
    endtask

    // stop pushing, wait for every cell, then let a silent step finish
    task automatic settle;
        push   <= 1'b0;
        in_gap = 0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_WIDTH) req_w = val;
        else req_h = val;
    endtask

    task automatic set_size(input logic [6:0] w, input logic [6:0] h);
        settle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_step(input logic [15:0] ra);
        send_cmd(CMD_STEP, ra, 16'($urandom), 1'b0, '0, '0);
    endtask

    task automatic send_start;
        send_cmd(CMD_START, 16'($urandom), 16'($urandom), 1'b0, '0, '0);
    endtask

    // directed rows
    typedef struct {
        logic        cmd;
        logic [15:0] ra;
        logic [15:0] rb;
        bit          typed;
        t_res        t0;
        t_res        t1;
    } t_row;

    t_row rows[$];

    task automatic put_row(input t_row r);
        rows = {rows, r};
    endtask

    task automatic add_row(input logic cmd, input logic [15:0] ra, input logic [15:0] rb);
        put_row('{cmd, ra, rb, 1'b0, '0, '0});
    endtask

    initial begin
        int n_items, steps;
        logic [6:0] pw, ph;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WIDTH;
        i_cfg_data = '0;
        push       = 1'b0;
        i_cmd      = CMD_STEP;
        i_rand_a   = '0;
        i_rand_b   = '0;
        n_errors   = 0;
        hold_out   = 1'b0;
        burst_in   = 1'b0;
        in_gap     = 0;
        req_w      = 7'(RESET_SIDE);
        req_h      = 7'(RESET_SIDE);
        foreach (map_cells[i]) map_cells[i] = 2'b00;
        foreach (trail[i]) trail[i] = '0;
        trail_len  = 0;
        first_hop  = 1'b1;
        maze_over  = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step before any start: done at once
        put_row('{CMD_STEP, 16'h0000, 16'h0000, 1'b1,
                  mk_res(0, 0, 1'b1, 1'b1), '0});
        // 15x15 after reset: top side pos 1, exit on the left side pos 1
        put_row('{CMD_START, 16'h0000, 16'h0000, 1'b1,
                  mk_res(1, 0, 1'b0, 1'b0), mk_res(0, 1, 1'b0, 1'b1)});
        for (int i = 0; i < 5; i++) add_row(CMD_STEP, 16'(i*3), 16'hFFFF);
        add_row(CMD_START, 16'hFFFF, 16'hFFFF);   // right side, high positions
        for (int i = 0; i < 4; i++) add_row(CMD_STEP, 16'hFFFF, 16'h0000);
        add_row(CMD_START, 16'h0001, 16'h0001);   // left side, exit pick 1
        add_row(CMD_STEP, 16'h8000, 16'h0000);
        add_row(CMD_STEP, 16'h7FFF, 16'h0000);
        add_row(CMD_START, 16'hAAAA, 16'h5502);   // bottom side, exit pick 2
        add_row(CMD_STEP, 16'h5555, 16'hAAAA);
        add_row(CMD_STEP, 16'h0002, 16'h0000);
        add_row(CMD_START, 16'h5557, 16'hAAFE);
        add_row(CMD_STEP, 16'h0003, 16'h0000);
        add_row(CMD_STEP, 16'h0001, 16'h0000);
        foreach (rows[i])
            send_cmd(rows[i].cmd, rows[i].ra, rows[i].rb, rows[i].typed, rows[i].t0, rows[i].t1);

        // smallest grid: runs to the end, then steps past it
        set_size(7'd5, 7'd5);
        send_start();
        for (int i = 0; i < 10; i++) send_step(16'($urandom));

        // random phases over sizes, extremes first
        n_items = 0;
        for (int p = 0; n_items < 470; p++) begin
            case (p)
                0:       begin pw = 7'd64;  ph = 7'd64;  end
                1:       begin pw = 7'd0;   ph = 7'd127; end
                2:       begin pw = 7'd127; ph = 7'd4;   end
                3:       begin pw = 7'd6;   ph = 7'd9;   end
                default: begin
                    pw = ($urandom_range(0, 2) == 0) ? 7'($urandom) : 7'($urandom_range(5, 11));
                    ph = ($urandom_range(0, 2) == 0) ? 7'($urandom) : 7'($urandom_range(5, 11));
                end
            endcase
            set_size(pw, ph);
            // occasionally keep the old maze, so stale cells meet a new size
            if (p < 4 || $urandom_range(0, 4) != 0) begin
                send_start();
                n_items++;
            end
            if (p == 1) hold_out = 1'b1;   // fill the block while nobody pops
            steps = $urandom_range(25, 60);
            for (int s = 0; s < steps; s++) begin
                if ($urandom_range(0, 39) == 0) send_start();
                else send_step(16'($urandom));
                n_items++;
                if (maze_over && $urandom_range(0, 3) == 0) break;
            end
        end

        settle();
        if (n_errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    initial begin
        int stall;
        t_res want;
        pop       = 1'b0;
        burst_out = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_out) begin
                pop <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_out = 1'b0;
            end
            stall = draw_wait(burst_out);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (cells_due.size() == 0) begin
                $error("result with nothing expected: x=%0d y=%0d done=%0b last=%0b",
                       o_cell_x, o_cell_y, o_done_res, o_last);
                n_errors++;
            end else begin
                want = cells_due.pop_front();
                if (o_cell_x !== want.x) begin
                    $error("cell_x: expected %0d, got %0d", want.x, o_cell_x);
                    n_errors++;
                end
                if (o_cell_y !== want.y) begin
                    $error("cell_y: expected %0d, got %0d", want.y, o_cell_y);
                    n_errors++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0b, got %0b", want.done, o_done_res);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/core/dmc_pkg.sv
rtl/core/dmc_fifo.sv
rtl/core/dmc_front.sv
rtl/core/dmc_back.sv
rtl/core/dfs_maze_carver_core.sv
bench/tb_top.sv
